@@ rtl/adcc_pkg.sv @@
// ----------------------------------------------------------------------------
// adcc_pkg
// Shared types and constants of the chained RC4-style cipher with keystream
// drop.
// ----------------------------------------------------------------------------
package adcc_pkg;

   localparam int BYTE_W      = 8;
   localparam int SBOX_DEPTH  = 256;
   localparam int SBOX_AW     = $clog2(SBOX_DEPTH);

   localparam int IV_MAX      = 128;
   localparam int PASS_MAX    = 64;
   localparam int RELAY_SLOTS = 4;
   localparam int HEADER_LEN  = 15 + RELAY_SLOTS;
   localparam int DROP_STEPS  = 4096;

   localparam int IV_AW       = (IV_MAX > 1) ? $clog2(IV_MAX) : 1;
   localparam int PASS_AW     = (PASS_MAX > 1) ? $clog2(PASS_MAX) : 1;
   localparam int KLEN_W      = $clog2(PASS_MAX + 1);
   localparam int MLEN_W      = $clog2(IV_MAX + 1);
   localparam int DROP_W      = (DROP_STEPS > 1) ? $clog2(DROP_STEPS + 1) : 1;

   localparam int OP_W        = 2;
   localparam int INDEX_W     = 7;
   localparam int LEN_W       = 10;
   localparam int KEYLEN_W    = 7;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 7;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD_IV   = 2'd0,
      OP_LOAD_PASS = 2'd1,
      OP_START     = 2'd2,
      OP_DATA      = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KEY_LENGTH   = 1'b0,
      CSR_DECRYPT_MODE = 1'b1
   } csr_index_type;

endpackage

@@ rtl/adcc_ram.sv @@
// ----------------------------------------------------------------------------
// adcc_ram
// Generic single-clock memory with one write port and one registered read
// port.
// ----------------------------------------------------------------------------
module adcc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/arc4_drop_chained_cipher.sv @@
// ----------------------------------------------------------------------------
// arc4_drop_chained_cipher
// Chained RC4-style stream cipher with a keystream drop after key setup.
// ----------------------------------------------------------------------------
// Usage: items arrive on the req_ channel (valid/stall) and results leave on
// the rsp_ channel. Load IV and load password items write their store in the
// cycle they are accepted. A start item sets up the S-box (a fill of all 256
// entries, then 256 key schedule steps and 4096 drop steps, each two reads
// and the two writes of the swap); req_stall is high for all of it. A data
// item runs the generator step and its swap (RD_A, RD_B, WR_A, WR_B) and
// the chain and output lookups (RD_C, RD_K, FIN), serialised on the single
// read port of the S-box memory; its result is held in the output register
// and no new item is taken until the item is done. Only data items give a
// result. While rsp_stall holds a result, loads and starts are still
// accepted; a data item waits in its last cycle until the output register
// is free. The user must write configuration on the csr_ port only while
// the block is idle; the block does not enforce it. Reset clears i, j, the
// chain byte and valid flag and resets the CSRs; the stores hold nothing valid until they are loaded.
// ----------------------------------------------------------------------------
module arc4_drop_chained_cipher (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [adcc_pkg::OP_W-1:0]       req_op,
   input  logic [adcc_pkg::INDEX_W-1:0]    req_index,
   input  logic [adcc_pkg::BYTE_W-1:0]     req_value,
   input  logic [adcc_pkg::LEN_W-1:0]      req_message_length,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [adcc_pkg::BYTE_W-1:0]     rsp_out_byte,
   input  logic                            csr_wr_en,
   input  logic [adcc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [adcc_pkg::CSR_DATA_W-1:0] csr_wdata
);

   import adcc_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_INIT = 9'b000000010,
      ST_RD_A = 9'b000000100,
      ST_RD_B = 9'b000001000,
      ST_WR_A = 9'b000010000,
      ST_WR_B = 9'b000100000,
      ST_RD_C = 9'b001000000,
      ST_RD_K = 9'b010000000,
      ST_FIN  = 9'b100000000
   } state_type;

   typedef enum logic [2:0] {
      PH_KSA  = 3'b001,
      PH_DROP = 3'b010,
      PH_DATA = 3'b100
   } phase_type;

   localparam logic [DROP_W-1:0] DROP_LAST =
      DROP_W'((DROP_STEPS > 0) ? DROP_STEPS - 1 : 0);

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;

   logic [SBOX_AW-1:0]  n_ff, n_in;
   logic [BYTE_W-1:0]   i_ff, i_in;
   logic [BYTE_W-1:0]   j_ff, j_in;
   logic [BYTE_W-1:0]   chain_ff, chain_in;
   logic [BYTE_W-1:0]   seed_ff, seed_in;
   logic [BYTE_W-1:0]   val_ff, val_in;
   logic [BYTE_W-1:0]   sa_ff, sa_in;
   logic [BYTE_W-1:0]   sj_ff, sj_in;
   logic [IV_AW-1:0]    iv_pos_ff, iv_pos_in;
   logic [PASS_AW-1:0]  pass_pos_ff, pass_pos_in;
   logic [DROP_W-1:0]   drop_cnt_ff, drop_cnt_in;
   logic [KEYLEN_W-1:0] key_length_ff;
   logic                decrypt_mode_ff;
   logic                rsp_valid_ff;
   logic [BYTE_W-1:0]   rsp_out_byte_ff;

   logic                req_accept;
   op_type              op;
   logic                rsp_load;
   logic [BYTE_W-1:0]   res;
   logic [BYTE_W-1:0]   j_sum;
   logic [BYTE_W-1:0]   j_extra;
   logic [SBOX_AW-1:0]  step_addr;

   logic [KLEN_W-1:0]   klen;
   logic [MLEN_W-1:0]   m_len;
   logic [IV_AW-1:0]    iv_last;
   logic [PASS_AW-1:0]  pass_last;

   logic                sb_wr_en;
   logic [SBOX_AW-1:0]  sb_wr_addr;
   logic [BYTE_W-1:0]   sb_wr_data;
   logic                sb_rd_en;
   logic [SBOX_AW-1:0]  sb_rd_addr;
   logic [BYTE_W-1:0]   sb_rd_data;

   logic                iv_wr_en;
   logic [BYTE_W-1:0]   iv_rd_data;
   logic                pass_wr_en;
   logic [BYTE_W-1:0]   pass_rd_data;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign op         = op_type'(req_op);

   // Effective key length and IV period of the key schedule.
   always_comb begin
      if (key_length_ff == '0) begin
         klen = KLEN_W'(1);
      end else if (32'(key_length_ff) > PASS_MAX) begin
         klen = KLEN_W'(PASS_MAX);
      end else begin
         klen = KLEN_W'(key_length_ff);
      end
      if (32'(klen) + HEADER_LEN > IV_MAX) begin
         m_len = MLEN_W'(IV_MAX);
      end else begin
         m_len = MLEN_W'(32'(klen) + HEADER_LEN);
      end
   end

   assign iv_last   = IV_AW'(m_len - MLEN_W'(1));
   assign pass_last = PASS_AW'(klen - KLEN_W'(1));

   assign iv_wr_en   = req_accept && (op == OP_LOAD_IV) && (32'(req_index) < IV_MAX);
   assign pass_wr_en = req_accept && (op == OP_LOAD_PASS) && (32'(req_index) < PASS_MAX);

   // The j adder of the generator: key bytes join in only during key setup.
   assign j_extra   = (phase_ff == PH_KSA) ? BYTE_W'(iv_rd_data + pass_rd_data) : '0;
   assign j_sum     = BYTE_W'(j_ff + sb_rd_data + j_extra);
   assign step_addr = (phase_ff == PH_KSA) ? n_ff : i_ff;
   assign res       = val_ff ^ sb_rd_data;

   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      n_in        = n_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      chain_in    = chain_ff;
      seed_in     = seed_ff;
      val_in      = val_ff;
      sa_in       = sa_ff;
      sj_in       = sj_ff;
      iv_pos_in   = iv_pos_ff;
      pass_pos_in = pass_pos_ff;
      drop_cnt_in = drop_cnt_ff;
      rsp_load    = 1'b0;
      sb_wr_en    = 1'b0;
      sb_wr_addr  = '0;
      sb_wr_data  = '0;
      sb_rd_en    = 1'b0;
      sb_rd_addr  = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               unique case (op)
                  OP_LOAD_IV, OP_LOAD_PASS: begin
                  end
                  OP_START: begin
                     seed_in  = req_message_length[BYTE_W-1:0];
                     n_in     = '0;
                     state_in = ST_INIT;
                  end
                  OP_DATA: begin
                     val_in   = req_value;
                     phase_in = PH_DATA;
                     state_in = ST_RD_A;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_INIT: begin
            sb_wr_en   = 1'b1;
            sb_wr_addr = n_ff;
            sb_wr_data = BYTE_W'(n_ff);
            n_in       = n_ff + 1'b1;
            if (n_ff == '1) begin
               phase_in    = PH_KSA;
               j_in        = '0;
               iv_pos_in   = '0;
               pass_pos_in = '0;
               state_in    = ST_RD_A;
            end
         end
         ST_RD_A: begin
            sb_rd_en = 1'b1;
            if (phase_ff == PH_KSA) begin
               sb_rd_addr = n_ff;
            end else begin
               sb_rd_addr = SBOX_AW'(i_ff + 1'b1);
               i_in       = i_ff + 1'b1;
            end
            state_in = ST_RD_B;
         end
         ST_RD_B: begin
            sa_in      = sb_rd_data;
            j_in       = j_sum;
            sb_rd_en   = 1'b1;
            sb_rd_addr = SBOX_AW'(j_sum);
            state_in   = ST_WR_A;
         end
         ST_WR_A: begin
            sj_in      = sb_rd_data;
            sb_wr_en   = 1'b1;
            sb_wr_addr = step_addr;
            sb_wr_data = sb_rd_data;
            state_in   = ST_WR_B;
         end
         ST_WR_B: begin
            sb_wr_en   = 1'b1;
            sb_wr_addr = SBOX_AW'(j_ff);
            sb_wr_data = sa_ff;
            unique case (phase_ff)
               PH_KSA: begin
                  n_in        = n_ff + 1'b1;
                  iv_pos_in   = (iv_pos_ff == iv_last) ? '0 : iv_pos_ff + 1'b1;
                  pass_pos_in = (pass_pos_ff == pass_last) ? '0 : pass_pos_ff + 1'b1;
                  state_in    = ST_RD_A;
                  if (n_ff == '1) begin
                     i_in        = '0;
                     j_in        = '0;
                     drop_cnt_in = '0;
                     if (DROP_STEPS == 0) begin
                        chain_in = seed_ff;
                        state_in = ST_IDLE;
                     end else begin
                        phase_in = PH_DROP;
                     end
                  end
               end
               PH_DROP: begin
                  drop_cnt_in = drop_cnt_ff + 1'b1;
                  if (drop_cnt_ff == DROP_LAST) begin
                     chain_in = seed_ff;
                     state_in = ST_IDLE;
                  end else begin
                     state_in = ST_RD_A;
                  end
               end
               PH_DATA: begin
                  state_in = ST_RD_C;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_RD_C: begin
            // The swap has landed, so this read sees the updated S-box.
            sb_rd_en   = 1'b1;
            sb_rd_addr = SBOX_AW'(chain_ff);
            state_in   = ST_RD_K;
         end
         ST_RD_K: begin
            sb_rd_en   = 1'b1;
            sb_rd_addr = SBOX_AW'(sa_ff + sj_ff + sb_rd_data);
            state_in   = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               chain_in = chain_ff ^ (decrypt_mode_ff ? val_ff : res);
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         phase_ff        <= PH_DATA;
         i_ff            <= '0;
         j_ff            <= '0;
         chain_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
         key_length_ff   <= KEYLEN_W'(1);
         decrypt_mode_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         chain_ff <= chain_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            unique case (csr_index_type'(csr_index))
               CSR_KEY_LENGTH:   key_length_ff   <= csr_wdata[KEYLEN_W-1:0];
               CSR_DECRYPT_MODE: decrypt_mode_ff <= csr_wdata[0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      seed_ff     <= seed_in;
      val_ff      <= val_in;
      sa_ff       <= sa_in;
      sj_ff       <= sj_in;
      iv_pos_ff   <= iv_pos_in;
      pass_pos_ff <= pass_pos_in;
      drop_cnt_ff <= drop_cnt_in;
      if (rsp_load) begin
         rsp_out_byte_ff <= res;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_out_byte_ff;

   adcc_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (SBOX_DEPTH)
   ) u_sbox (
      .clock   (clock),
      .wr_en   (sb_wr_en),
      .wr_addr (sb_wr_addr),
      .wr_data (sb_wr_data),
      .rd_en   (sb_rd_en),
      .rd_addr (sb_rd_addr),
      .rd_data (sb_rd_data)
   );

   adcc_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (IV_MAX)
   ) u_iv_store (
      .clock   (clock),
      .wr_en   (iv_wr_en),
      .wr_addr (IV_AW'(req_index)),
      .wr_data (req_value),
      .rd_en   (1'b1),
      .rd_addr (iv_pos_ff),
      .rd_data (iv_rd_data)
   );

   adcc_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (PASS_MAX)
   ) u_pass_store (
      .clock   (clock),
      .wr_en   (pass_wr_en),
      .wr_addr (PASS_AW'(req_index)),
      .wr_data (req_value),
      .rd_en   (1'b1),
      .rd_addr (pass_pos_ff),
      .rd_data (pass_rd_data)
   );

endmodule
